// File: src/rau_pkg.sv
// Package for the rational arithmetic unit: widths, operation codes, queue entry type.
// No dependencies.
`default_nettype none
package rau_pkg;
    localparam int Width = 32;
    localparam int FuncW = 3;

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_MUL = 3'd1,
        FN_DIV = 3'd2,
        FN_LT  = 3'd3,
        FN_EQ  = 3'd4,
        FN_NEG = 3'd5,
        FN_RED = 3'd6,
        FN_NOP = 3'd7
    } func_t;

    typedef struct packed {
        logic [Width-1:0] num;
        logic [Width-1:0] den;
        logic             lt;
        logic             eq;
        logic             ovf;
        logic             err;
        logic             reduce;
    } job_t;

    localparam int JobW = $bits(job_t);
endpackage
`default_nettype wire

// File: src/rau_front.sv
// Front end of the rational arithmetic unit: accepts a transaction, forms raw
// numerator/denominator and comparison bits over a few multiply steps. Uses rau_pkg.
`default_nettype none
module rau_front (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire  [2:0]               func,
    input  wire  [31:0]              a_num,
    input  wire  [31:0]              a_den,
    input  wire  [31:0]              b_num,
    input  wire  [31:0]              b_den,
    output logic                     job_valid,
    input  wire                      job_ready,
    output rau_pkg::job_t            job
);
    localparam int W = rau_pkg::Width;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_M0   = 5'b00010,
        S_M1   = 5'b00100,
        S_M2   = 5'b01000,
        S_OUT  = 5'b10000
    } fstate_t;

    fstate_t          state_reg, state_next;
    logic [2:0]       f_reg;
    logic signed [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [W-1:0] x_reg, y_reg, z_reg;
    logic             ovf_reg;
    logic signed [W-1:0] ma, mb;
    logic signed [2*W-1:0] prod;
    logic signed [W-1:0] pw;
    logic             pov;
    logic signed [W:0] sum;
    logic signed [W-1:0] sw;
    logic             sov;
    rau_pkg::job_t    job_reg;

    always_comb begin
        ma = an_reg;
        mb = bd_reg;
        case (state_reg)
            S_M0: begin
                ma = an_reg;
                mb = (rau_pkg::func_t'(f_reg) == rau_pkg::FN_MUL) ? bn_reg : bd_reg;
            end
            S_M1: begin
                ma = ad_reg;
                mb = (rau_pkg::func_t'(f_reg) == rau_pkg::FN_ADD) ? bn_reg : bd_reg;
            end
            S_M2: begin
                ma = ad_reg;
                mb = (rau_pkg::func_t'(f_reg) == rau_pkg::FN_ADD) ? bd_reg : bn_reg;
            end
            default: begin
                ma = an_reg;
                mb = bd_reg;
            end
        endcase
        prod = ma * mb;
        pw   = prod[W-1:0];
        pov  = (prod != {{W{pw[W-1]}}, pw});
        sum  = {x_reg[W-1], x_reg} + {z_reg[W-1], z_reg};
        sw   = sum[W-1:0];
        sov  = sum[W] != sum[W-1];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) begin
                state_next = S_M0;
            end
            S_M0: state_next = S_M1;
            S_M1: state_next = S_M2;
            S_M2: state_next = S_OUT;
            S_OUT: if (job_ready) begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        case (state_reg)
            S_IDLE: begin
                f_reg   <= func;
                an_reg  <= a_num[W-1:0];
                ad_reg  <= a_den[W-1:0];
                bn_reg  <= b_num[W-1:0];
                bd_reg  <= b_den[W-1:0];
                ovf_reg <= 1'b0;
            end
            S_M0: begin
                x_reg   <= pw;
                ovf_reg <= pov;
            end
            S_M1: begin
                z_reg <= pw;
                if (rau_pkg::func_t'(f_reg) == rau_pkg::FN_LT ||
                    rau_pkg::func_t'(f_reg) == rau_pkg::FN_MUL ||
                    rau_pkg::func_t'(f_reg) == rau_pkg::FN_ADD) begin
                    ovf_reg <= ovf_reg | pov;
                end
            end
            S_M2: begin
                y_reg <= pw;
                if (rau_pkg::func_t'(f_reg) == rau_pkg::FN_LT ||
                    rau_pkg::func_t'(f_reg) == rau_pkg::FN_EQ ||
                    rau_pkg::func_t'(f_reg) == rau_pkg::FN_ADD) begin
                    ovf_reg <= ovf_reg | pov;
                end
            end
            default: ;
        endcase
    end

    // S_M0: x = an*bd (or an*bn); S_M1: z = bn*ad (or ad*bd); S_M2: y = ad*bd or ad*bn
    always_comb begin
        job_reg        = '0;
        job_reg.num    = an_reg;
        job_reg.den    = ad_reg;
        job_reg.ovf    = ovf_reg;
        case (rau_pkg::func_t'(f_reg))
            rau_pkg::FN_ADD: begin
                job_reg.num    = sw;
                job_reg.den    = y_reg;
                job_reg.ovf    = ovf_reg | sov;
                job_reg.reduce = 1'b1;
            end
            rau_pkg::FN_MUL: begin
                job_reg.num    = x_reg;
                job_reg.den    = z_reg;
                job_reg.ovf    = ovf_reg & ~(1'b0);
                job_reg.reduce = 1'b1;
            end
            rau_pkg::FN_DIV: begin
                if (bn_reg == '0) begin
                    job_reg.num = '0;
                    job_reg.den = '0;
                    job_reg.err = 1'b1;
                    job_reg.ovf = 1'b0;
                end else begin
                    job_reg.num    = x_reg;
                    job_reg.den    = bn_reg;
                    job_reg.ovf    = ovf_reg;
                    job_reg.reduce = 1'b1;
                end
            end
            rau_pkg::FN_LT: begin
                job_reg.lt = (z_reg > 0) ? (x_reg < y_reg) : (x_reg > y_reg);
            end
            rau_pkg::FN_EQ: begin
                job_reg.eq = (x_reg == y_reg);
            end
            rau_pkg::FN_NEG: begin
                job_reg.num = -an_reg;
                job_reg.ovf = (an_reg == {1'b1, {(W-1){1'b0}}});
            end
            rau_pkg::FN_RED: begin
                job_reg.ovf    = 1'b0;
                job_reg.reduce = 1'b1;
            end
            default: job_reg.ovf = 1'b0;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign job_valid = (state_reg == S_OUT);
    assign job       = job_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && in_valid) |=> state_reg == S_M0)
        else $error("front did not start");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid && !job_ready) |=> job_valid)
        else $error("front dropped a job");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && job_valid))
        else $error("front ready while holding a job");
endmodule
`default_nettype wire

// File: src/rau_queue.sv
// Two-entry queue between the front and back ends of the rational arithmetic unit.
// Uses rau_pkg.
`default_nettype none
module rau_queue (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            wr_valid,
    output logic           wr_ready,
    input  rau_pkg::job_t  wr_data,
    output logic           rd_valid,
    input  wire            rd_ready,
    output rau_pkg::job_t  rd_data
);
    rau_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr_en, rd_en;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_en) begin
                wp_reg <= ~wp_reg;
            end
            if (rd_en) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
        if (wr_en) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !rd_en) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not advance");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !rd_valid)
        else $error("queue read while empty");
endmodule
`default_nettype wire

// File: src/rau_divider.sv
// Restoring bit-serial signed divider (truncating quotient and remainder) for the
// rational arithmetic unit. Uses rau_pkg.
`default_nettype none
module rau_divider (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         start,
    input  wire  [rau_pkg::Width-1:0]   dividend,
    input  wire  [rau_pkg::Width-1:0]   divisor,
    output logic                        done,
    output logic [rau_pkg::Width-1:0]   quot,
    output logic [rau_pkg::Width-1:0]   rem
);
    localparam int W  = rau_pkg::Width;
    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  q_reg, d_reg;
    logic [W:0]    r_reg;
    logic          qn_reg, rn_reg;
    logic [W:0]    shifted, trial;
    logic [W-1:0]  adiv, adsr;

    assign adiv    = dividend[W-1] ? -dividend : dividend;
    assign adsr    = divisor[W-1] ? -divisor : divisor;
    assign shifted = {r_reg[W-1:0], q_reg[W-1]};
    assign trial   = shifted - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
        if (start) begin
            q_reg  <= adiv;
            d_reg  <= adsr;
            r_reg  <= '0;
            qn_reg <= dividend[W-1] ^ divisor[W-1];
            rn_reg <= dividend[W-1];
        end else if (busy_reg) begin
            if (!trial[W]) begin
                r_reg <= trial;
                q_reg <= {q_reg[W-2:0], 1'b1};
            end else begin
                r_reg <= shifted;
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
        end
    end

    assign quot = qn_reg ? -q_reg : q_reg;
    assign rem  = rn_reg ? -r_reg[W-1:0] : r_reg[W-1:0];
endmodule
`default_nettype wire

// File: src/rau_back.sv
// Back end of the rational arithmetic unit: Euclid gcd by repeated remainder,
// then division of both parts, flags and output register. Uses rau_pkg, rau_divider.
`default_nettype none
module rau_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  job_valid,
    output logic                 job_ready,
    input  rau_pkg::job_t        job,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [31:0]          res_num,
    output logic [31:0]          res_den,
    output logic [6:0]           flags
);
    localparam int W = rau_pkg::Width;

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_GCD  = 7'b0000010,
        B_GW   = 7'b0000100,
        B_DN   = 7'b0001000,
        B_DNW  = 7'b0010000,
        B_DDW  = 7'b0100000,
        B_OUT  = 7'b1000000
    } bstate_t;

    bstate_t        state_reg, state_next;
    rau_pkg::job_t  j_reg;
    logic [W-1:0]   p_reg, q_reg;
    logic [W-1:0]   dv_a, dv_b, quot, rem;
    logic           dv_start, dv_done;
    logic [W-1:0]   rn_reg, rd_reg;
    logic           ovf_reg, err_reg;
    logic [W-1:0]   minv;

    assign minv = {1'b1, {(W-1){1'b0}}};

    rau_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dv_start),
        .dividend (dv_a),
        .divisor  (dv_b),
        .done     (dv_done),
        .quot     (quot),
        .rem      (rem)
    );

    always_comb begin
        dv_start = 1'b0;
        dv_a     = q_reg;
        dv_b     = p_reg;
        case (state_reg)
            B_GCD: dv_start = (p_reg != '0);
            B_DN: begin
                dv_start = 1'b1;
                dv_a     = j_reg.num;
                dv_b     = q_reg;
            end
            B_DNW: begin
                dv_start = dv_done;
                dv_a     = j_reg.den;
                dv_b     = q_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (job_valid) begin
                state_next = job.reduce ? B_GCD : B_OUT;
            end
            B_GCD: begin
                if (p_reg != '0) begin
                    state_next = B_GW;
                end else if (q_reg == '0) begin
                    state_next = B_OUT;
                end else begin
                    state_next = B_DN;
                end
            end
            B_GW:  if (dv_done) begin
                state_next = B_GCD;
            end
            B_DN:  state_next = B_DNW;
            B_DNW: if (dv_done) begin
                state_next = B_DDW;
            end
            B_DDW: if (dv_done) begin
                state_next = B_OUT;
            end
            B_OUT: if (out_ready) begin
                state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
        case (state_reg)
            B_IDLE: begin
                j_reg   <= job;
                p_reg   <= job.num;
                q_reg   <= job.den;
                rn_reg  <= job.num;
                rd_reg  <= job.den;
                ovf_reg <= job.ovf;
                err_reg <= job.err;
            end
            B_GCD: if (p_reg == '0 && q_reg == '0) begin
                err_reg <= 1'b1;
            end
            B_GW: if (dv_done) begin
                q_reg <= p_reg;
                p_reg <= rem;
            end
            B_DNW: if (dv_done) begin
                rn_reg <= quot;
                if (j_reg.num == minv && q_reg == '1) begin
                    ovf_reg <= 1'b1;
                end
            end
            B_DDW: if (dv_done) begin
                rd_reg <= quot;
                if (j_reg.den == minv && q_reg == '1) begin
                    ovf_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign job_ready = (state_reg == B_IDLE);
    assign out_valid = (state_reg == B_OUT);
    assign res_num   = 32'(signed'(rn_reg));
    assign res_den   = 32'(signed'(rd_reg));
    assign flags     = {ovf_reg, err_reg, (rn_reg != '0), (rn_reg == rd_reg),
                        (rn_reg == '0), j_reg.eq, j_reg.lt};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> (out_valid && $stable(res_num) && $stable(res_den)))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        dv_start |=> !dv_start)
        else $error("divider restarted while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_IDLE && job_valid && !job.reduce) |=> out_valid)
        else $error("plain job not forwarded");
endmodule
`default_nettype wire

// File: src/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: front end, job queue, back end.
// Uses rau_pkg, rau_front, rau_queue, rau_back.
//
// One transaction in gives one transaction out. The front end uses three shared
// 32x32 multiplies; add, multiply, divide and reduce then run a Euclid gcd in the
// back end, each remainder step a bit-serial division, followed by two more
// divisions for the result parts, while compare, negate and pass-through skip
// the gcd. The queue lets the front end take the next transaction while the
// back end is still reducing.
`default_nettype none
module rational_arithmetic_unit (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [127:0] s_tdata,   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
    input  wire  [2:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [63:0]  m_tdata,   // res_num[31:0], res_den[63:32]
    output logic [6:0]   m_tuser    // less, equal, is_zero, is_one, is_invertible, error, overflow
);
    logic          q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    rau_pkg::job_t q_in, q_out;
    logic [31:0]   rn, rd;

    rau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .func      (s_tuser),
        .a_num     (s_tdata[31:0]),
        .a_den     (s_tdata[63:32]),
        .b_num     (s_tdata[95:64]),
        .b_den     (s_tdata[127:96]),
        .job_valid (q_in_valid),
        .job_ready (q_in_ready),
        .job       (q_in)
    );

    rau_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_data  (q_in),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready),
        .rd_data  (q_out)
    );

    rau_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_out_valid),
        .job_ready (q_out_ready),
        .job       (q_out),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_num   (rn),
        .res_den   (rd),
        .flags     (m_tuser)
    );

    assign m_tdata = {rd, rn};
endmodule
`default_nettype wire
